@@ hw/rtl/jpeg_frame_locator_top_assert.svh @@
// Assertion macros used by the frame locator top level.
`ifndef JPEG_FRAME_LOCATOR_TOP_ASSERT_SVH
`define JPEG_FRAME_LOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JFL_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("frame locator check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define JFL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("frame locator check failed");

`endif

@@ hw/rtl/jfl_pkg.sv @@
// Shared types, constants and register indexes of the JPEG frame locator.
`timescale 1ns / 1ps

package jfl_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int IDX_W           = 21;
    localparam int START_FIELD_W   = 20;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [IDX_W-1:0] IDX_MAX        = {IDX_W{1'b1}};
    localparam logic [IDX_W-1:0] SCAN_LIMIT_MIN = IDX_W'(4);

    localparam logic [IDX_W-1:0] MIN_SIZE_RST   = IDX_W'(128);
    localparam logic [IDX_W-1:0] MAX_SIZE_RST   = IDX_W'(256 * 1024);
    localparam logic [IDX_W-1:0] SCAN_LIMIT_RST = IDX_W'(32'h4B000);

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;
    localparam logic [7:0] BYTE_SOS = 8'hDA;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SIZE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SIZE   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_LIMIT = CFG_INDEX_W'(2);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_FRAME,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [IDX_W-1:0] min_frame_size;
        logic [IDX_W-1:0] max_frame_size;
        logic [IDX_W-1:0] scan_limit;
    } t_cfg;

    typedef struct packed {
        logic                     found;
        logic [START_FIELD_W-1:0] start_offset;
        logic [IDX_W-1:0]         frame_size;
    } t_result;

endpackage

@@ hw/rtl/jfl_scanner.sv @@
// Marker scanner: per-buffer state and the result decision for one byte.
`timescale 1ns / 1ps

module jfl_scanner import jfl_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int START_W = (OFFSET_BITS < START_FIELD_W) ? OFFSET_BITS : START_FIELD_W;

    t_phase             r_phase, n_phase;
    logic               r_prev_ff, n_prev_ff;
    logic [IDX_W-1:0]   r_byte_index, n_byte_index;
    logic [START_W-1:0] r_frame_start, n_frame_start;
    logic               r_saw_scan, n_saw_scan;

    logic               w_examine;
    logic               w_is_ff;
    logic [IDX_W-1:0]   w_start_idx;
    logic               w_start_fits;
    logic [IDX_W-1:0]   w_size;
    logic               w_size_ok;
    logic               w_hit;

    assign w_examine    = (i_cfg.scan_limit >= SCAN_LIMIT_MIN)
                        && (r_byte_index < i_cfg.scan_limit)
                        && (r_phase != PH_DONE);
    assign w_is_ff      = (i_data_byte == BYTE_FF);
    // At offset zero the subtraction wraps, which fails the fit check as it should.
    assign w_start_idx  = r_byte_index - IDX_W'(1);
    assign w_start_fits = (w_start_idx[IDX_W-1:START_W] == '0);
    assign w_size       = r_byte_index - IDX_W'(r_frame_start) + IDX_W'(1);
    assign w_size_ok    = r_saw_scan
                        && (w_size >= i_cfg.min_frame_size)
                        && (w_size <= i_cfg.max_frame_size);
    assign w_hit        = w_examine && (r_phase == PH_FRAME) && r_prev_ff
                        && (i_data_byte == BYTE_EOI) && w_size_ok;

    // Next state.
    always_comb begin
        n_phase       = r_phase;
        n_prev_ff     = r_prev_ff;
        n_frame_start = r_frame_start;
        n_saw_scan    = r_saw_scan;
        n_byte_index  = r_byte_index;

        if (w_examine) begin
            case (r_phase)
                PH_SEEK: begin
                    if (r_prev_ff && (i_data_byte == BYTE_SOI) && w_start_fits) begin
                        n_phase       = PH_FRAME;
                        n_frame_start = w_start_idx[START_W-1:0];
                        n_saw_scan    = 1'b0;
                        n_prev_ff     = 1'b0;
                    end else begin
                        n_prev_ff = w_is_ff;
                    end
                end
                PH_FRAME: begin
                    if (r_prev_ff && (i_data_byte == BYTE_EOI)) begin
                        n_phase   = w_size_ok ? PH_DONE : PH_SEEK;
                        n_prev_ff = 1'b0;
                    end else begin
                        if (r_prev_ff && (i_data_byte == BYTE_SOS)) begin
                            n_saw_scan = 1'b1;
                        end
                        n_prev_ff = w_is_ff;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (r_byte_index != IDX_MAX) begin
            n_byte_index = r_byte_index + IDX_W'(1);
        end

        if (i_last) begin
            n_phase       = PH_SEEK;
            n_prev_ff     = 1'b0;
            n_byte_index  = '0;
            n_frame_start = '0;
            n_saw_scan    = 1'b0;
        end
    end

    // Result for this byte: a located frame, or a miss report at the end of the buffer.
    always_comb begin
        o_res_valid        = i_accept && (w_hit || (i_last && (r_phase != PH_DONE)));
        o_res.found        = w_hit;
        o_res.start_offset = w_hit ? START_FIELD_W'(r_frame_start) : '0;
        o_res.frame_size   = w_hit ? w_size : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SEEK;
            r_prev_ff     <= 1'b0;
            r_byte_index  <= '0;
            r_frame_start <= '0;
            r_saw_scan    <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_prev_ff     <= n_prev_ff;
            r_byte_index  <= n_byte_index;
            r_frame_start <= n_frame_start;
            r_saw_scan    <= n_saw_scan;
        end
    end

endmodule

@@ hw/rtl/jpeg_frame_locator_top.sv @@
// JPEG frame locator top level: configuration registers, scanner and output buffering.
// Throughput is one byte beat per cycle while the input is not stalled; the scanner state
// updates in the accepting cycle, and results leave through a registered output.
// A two-entry output buffer lets input beats keep flowing while one result waits downstream.
// Reset (synchronous, active low) loads the register defaults and starts a new buffer.
`timescale 1ns / 1ps

module jpeg_frame_locator_top import jfl_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Byte input channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last,
    // Result channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_found,
    output logic [START_FIELD_W-1:0] o_start_offset,
    output logic [IDX_W-1:0]         o_frame_size,
    // Configuration write port.
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [IDX_W-1:0]         i_cfg_data
);

`include "jpeg_frame_locator_top_assert.svh"

    // Configuration registers. Writes to an index outside the list are dropped.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_frame_size <= MIN_SIZE_RST;
            r_cfg.max_frame_size <= MAX_SIZE_RST;
            r_cfg.scan_limit     <= SCAN_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MIN_SIZE:   r_cfg.min_frame_size <= i_cfg_data;
                CFG_MAX_SIZE:   r_cfg.max_frame_size <= i_cfg_data;
                CFG_SCAN_LIMIT: r_cfg.scan_limit     <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The scanner does all of its work in the cycle a byte beat is accepted.
    logic    w_in_accept;
    logic    w_res_valid;
    t_result w_res;

    assign w_in_accept = i_in_valid && !o_in_stall;

    jfl_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register plus a skid entry. The input stalls only when the skid entry
    // is occupied, so a result waiting downstream does not stop the byte stream
    // until a second result is produced behind it.
    logic    r_out_vld, n_out_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_out_take;

    assign w_out_take = r_out_vld && !i_out_stall;
    assign o_in_stall = r_skid_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;

        if (r_skid_vld) begin
            // No byte is accepted while the skid entry is full; just drain it.
            if (w_out_take) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_vld || w_out_take) begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_res;
                n_skid_vld = 1'b1;
            end
        end else if (w_out_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_vld;
    assign o_found        = r_out.found;
    assign o_start_offset = r_out.start_offset;
    assign o_frame_size   = r_out.frame_size;

    // The skid entry is only ever filled behind a waiting output.
    `JFL_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    // A drained output with a full skid entry empties the skid entry.
    `JFL_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && !i_out_stall, !r_skid_vld)
    // A miss report carries zero offset and size.
    `JFL_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, r_out_vld && !r_out.found,
                      (r_out.start_offset == '0) && (r_out.frame_size == '0))
    // A located frame spans at least both markers, so its size is never zero.
    `JFL_ASSERT_IMPLY(a_found_size, i_clk, i_rst_n, r_out_vld && r_out.found,
                      r_out.frame_size != '0)

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the JPEG frame locator: directed table, random buffers.
`timescale 1ns / 1ps

module testbench import jfl_pkg::*;;

    // Largest start offset the scanner accepts with the default OFFSET_BITS.
    localparam int OFFSET_CAP = (OFFSET_BITS_DEF >= START_FIELD_W) ?
                                (1 << START_FIELD_W) - 1 : (1 << OFFSET_BITS_DEF) - 1;
    localparam logic [IDX_W-1:0] SIZE_TOP = IDX_W'(1048576);

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } t_row_kind;

    // One row of the directed table: either a byte beat or a register write.
    // Rows with typed set carry a result that is read straight off the spec.
    typedef struct packed {
        t_row_kind               kind;
        logic [7:0]              data_byte;
        logic                    last;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [IDX_W-1:0]        reg_value;
        logic                    typed;
        t_result                 want;
    } t_stim_row;

    localparam t_result NONE_FOUND = '0;
    localparam t_result FIRST_HIT  = '{found: 1'b1, start_offset: '0, frame_size: IDX_W'(6)};
    localparam int      ROWS       = 27;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic [7:0]               i_data_byte    = '0;
    logic                     i_last         = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic                     o_found;
    logic [START_FIELD_W-1:0] o_start_offset;
    logic [IDX_W-1:0]         o_frame_size;
    logic                     i_cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index    = '0;
    logic [IDX_W-1:0]         i_cfg_data     = '0;

    // Typed expectation that travels alongside the current byte beat.
    logic    beat_typed = 1'b0;
    t_result beat_want  = '0;

    // Shadow of the scanner: registers and per-buffer state.
    t_cfg             cfg_now      = '{MIN_SIZE_RST, MAX_SIZE_RST, SCAN_LIMIT_RST};
    t_phase           scan_phase   = PH_SEEK;
    logic             prev_ff      = 1'b0;
    logic [IDX_W-1:0] scan_index   = '0;
    logic [START_FIELD_W-1:0] frame_origin = '0;
    logic             scan_seen    = 1'b0;

    t_result     frame_reports[$];
    int unsigned mismatches   = 0;
    int unsigned beats_sent   = 0;
    int unsigned results_seen = 0;
    bit          steady_flow  = 1'b0;
    bit          hold_results = 1'b0;

    t_stim_row directed_rows [ROWS] = '{
        // After reset the minimum size is 128, so a one-byte buffer finds nothing.
        '{ROW_BEAT, 8'h00, 1'b1, CFG_MIN_SIZE,   '0,           1'b1, NONE_FOUND},
        '{ROW_REG,  8'h00, 1'b0, CFG_MIN_SIZE,   IDX_W'(6),    1'b0, NONE_FOUND},
        '{ROW_REG,  8'h00, 1'b0, CFG_MAX_SIZE,   IDX_W'(8),    1'b0, NONE_FOUND},
        // Smallest frame with a scan marker, found at offset zero.
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD8, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hDA, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD9, 1'b0, CFG_MIN_SIZE,   '0,           1'b1, FIRST_HIT},
        // Bytes after a hit are ignored up to last.
        '{ROW_BEAT, 8'h55, 1'b1, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        // A frame without a scan marker is dropped, the next one ends on last.
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD8, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD9, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD8, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hDA, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD9, 1'b1, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        // With the smallest scan limit the end marker lies past the examined bytes.
        '{ROW_REG,  8'h00, 1'b0, CFG_SCAN_LIMIT, IDX_W'(4),    1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD8, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hDA, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hFF, 1'b0, CFG_MIN_SIZE,   '0,           1'b0, NONE_FOUND},
        '{ROW_BEAT, 8'hD9, 1'b1, CFG_MIN_SIZE,   '0,           1'b1, NONE_FOUND}
    };

    jpeg_frame_locator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_start_offset (o_start_offset),
        .o_frame_size   (o_frame_size),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Advances the shadow scanner by one byte beat. Returns 1 when the beat
    // produces a result, which is then placed in report.
    function automatic bit locate_step(input logic [7:0] b, input logic is_last,
                                       output t_result report);
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] start_pos;
        logic [IDX_W-1:0] size;
        bit               made;
        idx    = scan_index;
        made   = 1'b0;
        report = '0;
        if (cfg_now.scan_limit >= SCAN_LIMIT_MIN && idx < cfg_now.scan_limit &&
            scan_phase != PH_DONE) begin
            start_pos = idx - 1'b1;
            if (scan_phase == PH_SEEK) begin
                if (prev_ff && b == BYTE_SOI && int'(start_pos) <= OFFSET_CAP) begin
                    scan_phase   = PH_FRAME;
                    frame_origin = start_pos[START_FIELD_W-1:0];
                    scan_seen    = 1'b0;
                    prev_ff      = 1'b0;
                end else begin
                    prev_ff = (b == BYTE_FF);
                end
            end else if (prev_ff && b == BYTE_EOI) begin
                size = idx - {1'b0, frame_origin} + 1'b1;
                if (scan_seen && size >= cfg_now.min_frame_size &&
                    size <= cfg_now.max_frame_size) begin
                    report.found        = 1'b1;
                    report.start_offset = frame_origin;
                    report.frame_size   = size;
                    made                = 1'b1;
                    scan_phase          = PH_DONE;
                end else begin
                    scan_phase = PH_SEEK;
                end
                prev_ff = 1'b0;
            end else begin
                if (prev_ff && b == BYTE_SOS) begin
                    scan_seen = 1'b1;
                end
                prev_ff = (b == BYTE_FF);
            end
        end
        if (scan_index != IDX_MAX) begin
            scan_index = scan_index + 1'b1;
        end
        // The last beat closes the buffer; it reports "none" unless a frame was found.
        if (is_last) begin
            if (scan_phase != PH_DONE) begin
                report = '0;
                made   = 1'b1;
            end
            scan_phase   = PH_SEEK;
            prev_ff      = 1'b0;
            scan_index   = '0;
            frame_origin = '0;
            scan_seen    = 1'b0;
        end
        return made;
    endfunction

    // Watches both channels and the register port at every edge. New
    // expectations are queued before results are checked, so ordering holds
    // even if a result were to follow its byte within the same edge.
    always @(posedge i_clk) begin : watch
        t_result predicted;
        t_result head;
        bit      made;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MIN_SIZE:   cfg_now.min_frame_size = i_cfg_data;
                    CFG_MAX_SIZE:   cfg_now.max_frame_size = i_cfg_data;
                    CFG_SCAN_LIMIT: cfg_now.scan_limit     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                made = locate_step(i_data_byte, i_last, predicted);
                if (beat_typed) begin
                    if (!made || predicted != beat_want) begin
                        $error("typed row: expected %h, predictor gives %h (made %0d)",
                               beat_want, predicted, made);
                        mismatches++;
                    end
                    frame_reports.push_back(beat_want);
                end else if (made) begin
                    frame_reports.push_back(predicted);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (frame_reports.size() == 0) begin
                    $error("result beat with nothing expected: found %0d offset %0h size %0h",
                           o_found, o_start_offset, o_frame_size);
                    mismatches++;
                end else begin
                    head = frame_reports.pop_front();
                    if (o_found !== head.found) begin
                        $error("found: expected %0d, got %0d", head.found, o_found);
                        mismatches++;
                    end
                    if (o_start_offset !== head.start_offset) begin
                        $error("start_offset: expected %0h, got %0h",
                               head.start_offset, o_start_offset);
                        mismatches++;
                    end
                    if (o_frame_size !== head.frame_size) begin
                        $error("frame_size: expected %0h, got %0h",
                               head.frame_size, o_frame_size);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side: random stall before each beat, plus one long hold-off that
    // lets the output buffer fill so the block must stall its byte input.
    initial begin : result_sink
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                i_out_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                hold_results = 1'b0;
            end
            gap = steady_flow ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offers one byte beat after a random gap and returns at the edge that takes it.
    task automatic send_beat(input logic [7:0] b, input logic is_last,
                             input logic typed, input t_result want);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last      <= is_last;
        beat_typed  <= typed;
        beat_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    // Stops offering bytes and waits until every expected result is out. The
    // extra cycles cover a byte still in flight that produces nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [IDX_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Bytes with a bias toward the marker values so that partial markers show up.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0, 1:    return BYTE_FF;
            2:       return BYTE_SOI;
            3:       return BYTE_EOI;
            4:       return BYTE_SOS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One capture buffer. Shaped buffers hold one or two frames with random
    // content around them; the rest are plain noise.
    task automatic send_buffer(input bit shaped);
        logic [7:0] bytes[$];
        int         frames;
        frames = shaped ? $urandom_range(1, 2) : 0;
        repeat ($urandom_range(0, 3)) bytes.push_back(noise_byte());
        repeat (frames) begin
            bytes.push_back(BYTE_FF);
            bytes.push_back(BYTE_SOI);
            repeat ($urandom_range(0, 5)) bytes.push_back(noise_byte());
            if ($urandom_range(0, 3) != 0) begin
                bytes.push_back(BYTE_FF);
                bytes.push_back(BYTE_SOS);
            end
            repeat ($urandom_range(0, 6)) bytes.push_back(noise_byte());
            bytes.push_back(BYTE_FF);
            bytes.push_back(BYTE_EOI);
            repeat ($urandom_range(0, 3)) bytes.push_back(noise_byte());
        end
        if (!shaped) begin
            repeat ($urandom_range(1, 16)) bytes.push_back(noise_byte());
        end
        foreach (bytes[i]) begin
            send_beat(bytes[i], i == bytes.size() - 1, 1'b0, NONE_FOUND);
        end
    endtask

    initial begin : stimulus
        t_cfg settings [5];
        int   phase_start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                drain();
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
            end else begin
                send_beat(directed_rows[r].data_byte, directed_rows[r].last,
                          directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Register settings for the random part, extremes included.
        settings[0] = '{IDX_W'(0), SIZE_TOP, SIZE_TOP};
        settings[1] = '{IDX_W'(6), IDX_W'(10), SIZE_TOP};
        settings[2] = '{IDX_W'(8), IDX_W'(14), IDX_W'(12)};
        settings[3] = '{SIZE_TOP, IDX_W'(0), IDX_W'(4)};
        settings[4].min_frame_size = IDX_W'($urandom_range(4, 10));
        settings[4].max_frame_size = settings[4].min_frame_size + IDX_W'($urandom_range(0, 6));
        settings[4].scan_limit     = IDX_W'($urandom_range(8, 24));

        for (int p = 0; p < 5; p++) begin
            drain();
            write_reg(CFG_MIN_SIZE, settings[p].min_frame_size);
            write_reg(CFG_MAX_SIZE, settings[p].max_frame_size);
            write_reg(CFG_SCAN_LIMIT, settings[p].scan_limit);
            // Phase 0 holds the result side back for a long stretch; phase 1
            // runs with no idle cycles on either side.
            hold_results = (p == 0);
            steady_flow  = (p == 1);
            phase_start  = beats_sent;
            while (beats_sent - phase_start < 70) begin
                send_buffer($urandom_range(0, 3) != 0);
            end
            steady_flow = 1'b0;
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d byte beats and %0d result beats: the directed table, then",
                 beats_sent, results_seen);
        $display("five register settings with random buffers, a long output hold and drains.");
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest legal run.
    initial begin : watchdog
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/jfl_pkg.sv
hw/rtl/jfl_scanner.sv
hw/rtl/jpeg_frame_locator_top.sv
bench/testbench.sv
